// ----- rtl/a2u_pkg.sv -----
// ============================================================================
// a2u_pkg
// Shared types, character codes and the digit decoder of the string-to-
// unsigned parser.
// ============================================================================
package a2u_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_NUMBER_BASE = 1'b0;
   localparam logic [5:0] NUMBER_BASE_RESET = 6'd10;

   // Radix codes
   localparam logic [5:0] BASE_AUTO = 6'd0;
   localparam logic [5:0] BASE_OCT  = 6'd8;
   localparam logic [5:0] BASE_DEC  = 6'd10;
   localparam logic [5:0] BASE_HEX  = 6'd16;

   // Character codes
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] NOT_DIGIT  = 8'hFF;

   typedef enum logic [1:0] {
      ST_NONE,
      ST_FOUND,
      ST_OVER
   } dstat_type;

   typedef struct packed {
      logic      stop;
      dstat_type stat;
   } feed_ctl_type;

   // Digit value of a character, NOT_DIGIT for anything else
   function automatic logic [7:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = NOT_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         d = c - (CH_UPPER_A - 8'd10);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         d = c - (CH_LOWER_A - 8'd10);
      end
      return d;
   endfunction

endpackage

// ----- rtl/a2u_csr.sv -----
// ============================================================================
// a2u_csr
// Configuration register file: holds the number base.
// ============================================================================
module a2u_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [a2u_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output logic [5:0]                       number_base
);

   logic [5:0] base_ff;
   logic [5:0] base_in;
   logic       hit;

   assign hit = (csr_paddr[2] == a2u_pkg::REG_NUMBER_BASE);

   always_comb begin
      base_in = base_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         base_in = csr_pwdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= a2u_pkg::NUMBER_BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   assign csr_prdata  = hit ? {26'd0, base_ff} : 32'd0;
   assign csr_pready  = 1'b1;
   assign number_base = base_ff;

endmodule

// ----- rtl/a2u_feed.sv -----
// ============================================================================
// a2u_feed
// One digit step: multiply-add into the accumulator with saturation.
// ============================================================================
module a2u_feed #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic [7:0]               digit,
   input  logic [5:0]               base,
   input  logic [VALUE_WIDTH-1:0]   acc_src,
   input  a2u_pkg::dstat_type       stat_src,
   output logic [VALUE_WIDTH-1:0]   acc_out,
   output a2u_pkg::feed_ctl_type    ctl
);

   localparam int PW = VALUE_WIDTH + 6;

   logic [PW-1:0] prod;
   logic          over;

   // acc*base + d exceeds the width exactly when the strtoul cutoff test trips
   assign prod = PW'(acc_src) * PW'(base) + PW'(digit[5:0]);
   assign over = |prod[PW-1:VALUE_WIDTH];

   always_comb begin
      acc_out  = acc_src;
      ctl.stop = ({2'b00, base} <= digit);
      ctl.stat = stat_src;
      if (!ctl.stop && stat_src != a2u_pkg::ST_OVER) begin
         if (over) begin
            acc_out  = '1;
            ctl.stat = a2u_pkg::ST_OVER;
         end else begin
            acc_out  = prod[VALUE_WIDTH-1:0];
            ctl.stat = a2u_pkg::ST_FOUND;
         end
      end
   end

endmodule

// ----- rtl/ascii_to_unsigned_parser.sv -----
// ============================================================================
// ascii_to_unsigned_parser
// Streaming strtoul: one character per item, one result on the last item.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/ready    | char_code[7:0], last_char
//   rsp     | out       | rsp_valid/ready    | value[63:0], end_offset[11:0],
//           |           |                    | digits_found, overflowed
//   csr     | in        | APB psel/penable   | number_base[5:0] at byte address 0
//
// One item per cycle unless a last character waits on a stalled result. An
// item is held in the input register; the parse step (digit decode, one
// VALUE_WIDTH x 6 multiply-add, saturation check) runs between that
// register and the parse state / result register, so a result is
// registered when its last character advances out of the input register.
// Synchronous active-high reset clears the parse state, the valid flags and
// sets number_base to 10. An input item holds in the input register only when
// it is a last character and the result register is full and stalled.
// ============================================================================
module ascii_to_unsigned_parser #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_CHARS   = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_char_code,
   input  logic                             req_last_char,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [63:0]                      rsp_value,
   output logic [11:0]                      rsp_end_offset,
   output logic                             rsp_digits_found,
   output logic                             rsp_overflowed,
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [a2u_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int PW = $clog2(MAX_CHARS);
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_CHARS - 1);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_FIRST,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // ---------------------------------------------------------------- config
   logic [5:0] number_base;

   a2u_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .number_base (number_base)
   );

   // ------------------------------------------------------- input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff,     char_in;
   logic       last_ff,     last_in;
   logic       fire;

   // ------------------------------------------------------------ parse state
   phase_type              phase_ff, phase_in, phase_nx;
   logic                   neg_ff,   neg_in,   neg_nx;
   logic                   zp_ff,    zp_in,    zp_nx;
   logic [5:0]             ab_ff,    ab_in,    ab_nx;
   logic [VALUE_WIDTH-1:0] acc_ff,   acc_in,   acc_nx;
   a2u_pkg::dstat_type     stat_ff,  stat_in,  stat_nx, stat_fin;
   logic [PW-1:0]          pos_ff,   pos_in;
   logic [PW-1:0]          stop_ff,  stop_in,  stop_nx;
   phase_type              phase_fin;

   // ------------------------------------------------------- result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            value_ff,  value_in;
   logic [11:0]            end_ff,    end_in;
   logic                   found_ff,  found_in;
   logic                   over_ff,   over_in;

   // ---------------------------------------------------------- step signals
   logic                   is_space;
   logic                   zero_first;
   logic                   go_first;
   logic                   use_feed;
   logic [VALUE_WIDTH-1:0] f_acc;
   logic [5:0]             f_base;
   a2u_pkg::dstat_type     f_stat;
   logic [VALUE_WIDTH-1:0] feed_acc;
   a2u_pkg::feed_ctl_type  feed_ctl;
   logic [7:0]             digit;
   logic [PW-1:0]          end_pos;
   logic [PW+11:0]         end_wide;
   logic [VALUE_WIDTH-1:0] val;

   // Advance the held item unless it would produce a result into a full,
   // stalled result register.
   assign fire      = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      last_in     = last_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         char_in     = req_char_code;
         last_in     = req_last_char;
      end
   end

   assign digit    = a2u_pkg::digit_of(char_ff);
   assign is_space = (char_ff == a2u_pkg::CH_SPACE) ||
                     (char_ff >= a2u_pkg::CH_TAB && char_ff <= a2u_pkg::CH_CR);
   // A leading '0' might open an 0x prefix: hold it back one character
   assign zero_first = (number_base == a2u_pkg::BASE_AUTO ||
                        number_base == a2u_pkg::BASE_HEX) &&
                       (char_ff == a2u_pkg::CH_ZERO);

   a2u_feed #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_feed (
      .digit    (digit),
      .base     (f_base),
      .acc_src  (f_acc),
      .stat_src (f_stat),
      .acc_out  (feed_acc),
      .ctl      (feed_ctl)
   );

   // One character of the parse: next state after this item
   always_comb begin
      phase_nx = phase_ff;
      neg_nx   = neg_ff;
      zp_nx    = zp_ff;
      ab_nx    = ab_ff;
      acc_nx   = acc_ff;
      stat_nx  = stat_ff;
      stop_nx  = stop_ff;
      go_first = 1'b0;
      use_feed = 1'b0;
      f_acc    = acc_ff;
      f_base   = ab_ff;
      f_stat   = stat_ff;

      unique case (phase_ff)
         PH_SPACE: begin
            if (is_space) begin
               phase_nx = PH_SPACE;
            end else if (char_ff == a2u_pkg::CH_MINUS) begin
               neg_nx   = 1'b1;
               phase_nx = PH_FIRST;
            end else if (char_ff == a2u_pkg::CH_PLUS) begin
               phase_nx = PH_FIRST;
            end else begin
               go_first = 1'b1;
            end
         end
         PH_FIRST: begin
            if (zp_ff) begin
               zp_nx = 1'b0;
               if (char_ff == a2u_pkg::CH_LOWER_X || char_ff == a2u_pkg::CH_UPPER_X) begin
                  ab_nx    = a2u_pkg::BASE_HEX;
                  phase_nx = PH_DIGITS;
               end else begin
                  // The held zero was a digit: value 0, then feed this char
                  use_feed = 1'b1;
                  f_acc    = '0;
                  f_base   = (ab_ff == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_OCT
                                                           : a2u_pkg::BASE_HEX;
                  f_stat   = a2u_pkg::ST_FOUND;
               end
            end else begin
               go_first = 1'b1;
            end
         end
         PH_DIGITS: begin
            use_feed = 1'b1;
         end
         PH_DONE: begin
            phase_nx = PH_DONE;
         end
         default: begin
            phase_nx = PH_DONE;
         end
      endcase

      if (go_first) begin
         if (zero_first) begin
            ab_nx    = number_base;
            zp_nx    = 1'b1;
            phase_nx = PH_FIRST;
         end else begin
            use_feed = 1'b1;
            f_base   = (number_base == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_DEC
                                                           : number_base;
         end
      end

      if (use_feed) begin
         ab_nx   = f_base;
         acc_nx  = feed_acc;
         stat_nx = feed_ctl.stat;
         if (feed_ctl.stop) begin
            phase_nx = PH_DONE;
            stop_nx  = pos_ff;
         end else begin
            phase_nx = PH_DIGITS;
         end
      end
   end

   // End of string: resolve a still-held zero, form the result, clear state
   always_comb begin
      phase_fin = phase_nx;
      stat_fin  = stat_nx;
      if (zp_nx) begin
         phase_fin = PH_DIGITS;
         stat_fin  = a2u_pkg::ST_FOUND;
      end

      end_pos = '0;
      if (phase_fin == PH_DIGITS) begin
         end_pos = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;
      end else if (phase_fin == PH_DONE) begin
         end_pos = stop_nx;
      end
      if (stat_fin == a2u_pkg::ST_NONE) begin
         end_pos = '0;
      end
      end_wide = (PW + 12)'(end_pos);

      val = acc_nx;
      if (neg_nx && stat_fin == a2u_pkg::ST_FOUND) begin
         val = '0 - acc_nx;
      end

      value_in = value_ff;
      end_in   = end_ff;
      found_in = found_ff;
      over_in  = over_ff;
      if (fire && last_ff) begin
         value_in = 64'(val);
         end_in   = end_wide[11:0];
         found_in = (stat_fin != a2u_pkg::ST_NONE);
         over_in  = (stat_fin == a2u_pkg::ST_OVER);
      end
      rsp_valid_in = (fire && last_ff) || (rsp_valid_ff && !rsp_ready);

      phase_in = phase_ff;
      neg_in   = neg_ff;
      zp_in    = zp_ff;
      ab_in    = ab_ff;
      acc_in   = acc_ff;
      stat_in  = stat_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      if (fire) begin
         if (last_ff) begin
            phase_in = PH_SPACE;
            neg_in   = 1'b0;
            zp_in    = 1'b0;
            ab_in    = '0;
            acc_in   = '0;
            stat_in  = a2u_pkg::ST_NONE;
            pos_in   = '0;
            stop_in  = '0;
         end else begin
            phase_in = phase_nx;
            neg_in   = neg_nx;
            zp_in    = zp_nx;
            ab_in    = ab_nx;
            acc_in   = acc_nx;
            stat_in  = stat_nx;
            stop_in  = stop_nx;
            // Saturate the position at the last countable index
            pos_in   = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         zp_ff        <= 1'b0;
         ab_ff        <= '0;
         acc_ff       <= '0;
         stat_ff      <= a2u_pkg::ST_NONE;
         pos_ff       <= '0;
         stop_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         zp_ff        <= zp_in;
         ab_ff        <= ab_in;
         acc_ff       <= acc_in;
         stat_ff      <= stat_in;
         pos_ff       <= pos_in;
         stop_ff      <= stop_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      last_ff  <= last_in;
      value_ff <= value_in;
      end_ff   <= end_in;
      found_ff <= found_in;
      over_ff  <= over_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_end_offset   = end_ff;
   assign rsp_digits_found = found_ff;
   assign rsp_overflowed   = over_ff;

endmodule
